>>> src/rgb_cube_color_separation_defines.svh
// Assertion macros used by the controller module.
`ifndef RGB_CUBE_COLOR_SEPARATION_DEFINES_SVH
`define RGB_CUBE_COLOR_SEPARATION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/rcs_pkg.sv
package rcs_pkg;

  // request codes on req_type
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TABLE  = 2'd1,
    REQ_RGB    = 2'd2,
    REQ_GRAY   = 2'd3
  } req_t;

  // configuration register indexes
  localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [1:0] CFG_CHANNELS  = 2'd1;

  // lerp sequence: blue pairs, green, then red
  localparam logic [2:0] STEP_A_LO = 3'd0;
  localparam logic [2:0] STEP_B_LO = 3'd1;
  localparam logic [2:0] STEP_LO   = 3'd2;
  localparam logic [2:0] STEP_A_HI = 3'd3;
  localparam logic [2:0] STEP_B_HI = 3'd4;
  localparam logic [2:0] STEP_HI   = 3'd5;
  localparam logic [2:0] STEP_T    = 3'd6;

  localparam logic [2:0] LAST_CORNER = 3'd7;

  // table read selectors
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       clr;
    logic       tab_wr;
    logic [1:0] tab_sel;
    logic       lin_cap;
    logic [1:0] lin_sel;
    logic       samp_idx;
    logic       pix_idx;
    logic       samp_wr;
    logic       cube_rd;
    logic [2:0] rd_corner;
    logic       word_cap;
    logic [2:0] cap_corner;
    logic       lerp;
    logic [2:0] step;
    logic       out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_done;
    logic out_free;
  } stat_t;

endpackage

>>> src/rcs_ram.sv
module rcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

>>> src/rcs_dp.sv
module rcs_dp #(
  parameter int MAX_GRID = 16,
  parameter int MAX_INKS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  rcs_pkg::cmd_t cmd,
  output rcs_pkg::stat_t stat,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  input  logic [7:0]    sample_c0,
  input  logic [7:0]    sample_c1,
  input  logic [7:0]    sample_c2,
  input  logic [7:0]    sample_c3,
  input  logic          last_in,
  input  logic          req_gray,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    sep_c0,
  output logic [7:0]    sep_c1,
  output logic [7:0]    sep_c2,
  output logic [7:0]    sep_c3,
  output logic          last_out
);
  import rcs_pkg::*;

  localparam int GW    = $clog2(MAX_GRID);
  localparam int DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 8 + GW;

  function automatic logic [AW-1:0] addr_of(logic [GW-1:0] r, logic [GW-1:0] g,
                                            logic [GW-1:0] b);
    int a;
    a = (int'(r) * MAX_GRID + int'(g)) * MAX_GRID + int'(b);
    return AW'(a);
  endfunction

  // weight of the lower grid point
  function automatic logic [8:0] weight0(logic [7:0] v, logic [PW-1:0] p);
    logic [8:0] w;
    w = (v == 8'd0) ? 9'd256 : (9'd255 - {1'b0, p[7:0]});
    return w;
  endfunction

  // configuration registers
  logic [4:0] grid_size;
  logic [2:0] channel_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size     <= 5'd16;
      channel_count <= 3'd4;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_GRID_SIZE) grid_size <= cfg_data[4:0];
      else if (cfg_index == CFG_CHANNELS) channel_count <= cfg_data[2:0];
    end
  end

  logic [4:0]    grid_eff;
  logic [GW-1:0] sm1;
  logic [2:0]    inks;
  always_comb begin
    if (grid_size < 5'd2) grid_eff = 5'd2;
    else if (grid_size > 5'(MAX_GRID)) grid_eff = 5'(MAX_GRID);
    else grid_eff = grid_size;
    sm1 = GW'(grid_eff - 5'd1);
    if (channel_count < 3'd1) inks = 3'd1;
    else if (channel_count > 3'(MAX_INKS)) inks = 3'(MAX_INKS);
    else inks = channel_count;
  end

  // captured input word
  logic [7:0]  red_q, green_q, blue_q;
  logic [31:0] samp_q;
  logic        last_q, gray_q;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
      samp_q  <= {sample_c3, sample_c2, sample_c1, sample_c0};
      last_q  <= last_in;
      gray_q  <= req_gray;
    end
  end

  // clearing pass address
  logic [AW-1:0] clr_addr;
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr) clr_addr <= clr_addr + AW'(1);
  end
  assign stat.clear_done = (clr_addr == AW'(DEPTH - 1));

  // linearization table
  logic [7:0] tab_addr, tab_rdata;
  always_comb begin
    case (cmd.tab_sel)
      SEL_GREEN: tab_addr = green_q;
      SEL_BLUE:  tab_addr = blue_q;
      default:   tab_addr = red_q;
    endcase
    if (cmd.tab_wr) tab_addr = red_q;
  end

  rcs_ram #(.WIDTH(8), .DEPTH(256)) u_tab (
    .clk(clk), .we(cmd.tab_wr), .addr(tab_addr), .wdata(green_q), .rdata(tab_rdata)
  );

  logic [7:0] lin_r, lin_g, lin_b;
  always_ff @(posedge clk) begin
    if (cmd.lin_cap) begin
      case (cmd.lin_sel)
        SEL_GREEN: lin_g <= tab_rdata;
        SEL_BLUE:  lin_b <= tab_rdata;
        default:   lin_r <= tab_rdata;
      endcase
    end
  end

  // grid indices and weights
  logic [GW-1:0] ri_q, gi_q, bi_q;
  logic [8:0]    rm0_q, gm0_q, bm0_q;
  logic [PW-1:0] pr, pg, pb, sr, sg, sb;
  logic [PW+1:0] qr, qg, qb;
  always_comb begin
    pr = PW'(lin_r) * PW'(sm1);
    pg = PW'(lin_g) * PW'(sm1);
    pb = PW'(lin_b) * PW'(sm1);
    sr = PW'(red_q) * PW'(sm1);
    sg = PW'(green_q) * PW'(sm1);
    sb = PW'(blue_q) * PW'(sm1);
    // x/255 as (x + (x>>8) + 1) >> 8
    qr = ((PW+2)'(sr) + (PW+2)'(sr >> 8) + (PW+2)'(1)) >> 8;
    qg = ((PW+2)'(sg) + (PW+2)'(sg >> 8) + (PW+2)'(1)) >> 8;
    qb = ((PW+2)'(sb) + (PW+2)'(sb >> 8) + (PW+2)'(1)) >> 8;
  end

  always_ff @(posedge clk) begin
    if (cmd.samp_idx) begin
      ri_q <= GW'(qr);
      gi_q <= GW'(qg);
      bi_q <= GW'(qb);
    end else if (cmd.pix_idx) begin
      ri_q  <= GW'(pr >> 8);
      rm0_q <= weight0(lin_r, pr);
      if (gray_q) begin
        gi_q  <= GW'(pr >> 8);
        bi_q  <= GW'(pr >> 8);
        gm0_q <= 9'd256;
        bm0_q <= 9'd256;
      end else begin
        gi_q  <= GW'(pg >> 8);
        bi_q  <= GW'(pb >> 8);
        gm0_q <= weight0(lin_g, pg);
        bm0_q <= weight0(lin_b, pb);
      end
    end
  end

  // corner address; gray walks the diagonal on the red bit
  logic [GW-1:0] cr, cg, cb;
  always_comb begin
    cr = GW'({1'b0, ri_q} + (GW+1)'(cmd.rd_corner[2]));
    if (gray_q) begin
      cg = cr;
      cb = cr;
    end else begin
      cg = GW'({1'b0, gi_q} + (GW+1)'(cmd.rd_corner[1]));
      cb = GW'({1'b0, bi_q} + (GW+1)'(cmd.rd_corner[0]));
    end
  end

  // cube store
  logic [AW-1:0] cube_addr;
  logic [31:0]   cube_wdata, cube_rdata, merged;
  logic          cube_we;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (c < MAX_INKS && 3'(c) < inks) merged[8*c +: 8] = samp_q[8*c +: 8];
      else merged[8*c +: 8] = cube_rdata[8*c +: 8];
    end
    if (cmd.clr) cube_addr = clr_addr;
    else if (cmd.cube_rd) cube_addr = addr_of(cr, cg, cb);
    else cube_addr = addr_of(ri_q, gi_q, bi_q);
    cube_we    = cmd.clr | cmd.samp_wr;
    cube_wdata = cmd.clr ? 32'd0 : merged;
  end

  rcs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_cube (
    .clk(clk), .we(cube_we), .addr(cube_addr), .wdata(cube_wdata), .rdata(cube_rdata)
  );

  logic [31:0] word_q [8];
  always_ff @(posedge clk) begin
    if (cmd.word_cap) word_q[cmd.cap_corner] <= cube_rdata;
  end

  // shared lerp unit, four lanes
  logic [31:0] a_q, b_q, lo_q, hi_q, t_q;
  logic [31:0] lx, ly, lres;
  logic [8:0]  lm0, lm1;
  logic [16:0] lsum;
  always_comb begin
    case (cmd.step)
      STEP_A_LO: begin lx = word_q[0]; ly = word_q[1]; lm0 = bm0_q; end
      STEP_B_LO: begin lx = word_q[2]; ly = word_q[3]; lm0 = bm0_q; end
      STEP_LO:   begin lx = a_q;       ly = b_q;       lm0 = gm0_q; end
      STEP_A_HI: begin lx = word_q[4]; ly = word_q[5]; lm0 = bm0_q; end
      STEP_B_HI: begin lx = word_q[6]; ly = word_q[7]; lm0 = bm0_q; end
      STEP_HI:   begin lx = a_q;       ly = b_q;       lm0 = gm0_q; end
      default:   begin lx = lo_q;      ly = hi_q;      lm0 = rm0_q; end
    endcase
    lm1  = 9'd256 - lm0;
    lsum = '0;
    for (int c = 0; c < 4; c++) begin
      lsum = 17'(lx[8*c +: 8]) * 17'(lm0) + 17'(ly[8*c +: 8]) * 17'(lm1);
      lres[8*c +: 8] = (lsum[16:8] > 9'd255) ? 8'd255 : lsum[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lerp) begin
      case (cmd.step)
        STEP_A_LO, STEP_A_HI: a_q  <= lres;
        STEP_B_LO, STEP_B_HI: b_q  <= lres;
        STEP_LO:              lo_q <= lres;
        STEP_HI:              hi_q <= lres;
        default:              t_q  <= lres;
      endcase
    end
  end

  // output register
  logic [31:0] t_mask;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      t_mask[8*c +: 8] = (c < MAX_INKS && 3'(c) < inks) ? t_q[8*c +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.out_load) begin
      {sep_c3, sep_c2, sep_c1, sep_c0} <= t_mask;
      last_out <= last_q;
    end
  end
  assign stat.out_free = !out_valid || out_ready;

endmodule

>>> src/rcs_ctrl.sv
`include "rgb_cube_color_separation_defines.svh"

module rcs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     req_type,
  input  rcs_pkg::stat_t stat,
  output rcs_pkg::cmd_t  cmd
);
  import rcs_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TABW, S_SIDX, S_SRD, S_SWR,
    S_LIN0, S_LIN1, S_LIN2, S_LIN3, S_PIDX, S_RD, S_RDL, S_LERP, S_OUT
  } state_t;

  state_t     state;
  logic [2:0] cnt;

  assign in_ready = (state == S_IDLE);

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: if (stat.clear_done) state <= S_IDLE;
        S_IDLE: begin
          if (in_valid) begin
            unique case (req_t'(req_type))
              REQ_SAMPLE: state <= S_SIDX;
              REQ_TABLE:  state <= S_TABW;
              default:    state <= S_LIN0;
            endcase
          end
        end
        S_TABW: state <= S_IDLE;
        S_SIDX: state <= S_SRD;
        S_SRD:  state <= S_SWR;
        S_SWR:  state <= S_IDLE;
        S_LIN0: state <= S_LIN1;
        S_LIN1: state <= S_LIN2;
        S_LIN2: state <= S_LIN3;
        S_LIN3: state <= S_PIDX;
        S_PIDX: begin
          state <= S_RD;
          cnt   <= '0;
        end
        S_RD: begin
          cnt <= cnt + 3'd1;
          if (cnt == LAST_CORNER) state <= S_RDL;
        end
        S_RDL: begin
          state <= S_LERP;
          cnt   <= '0;
        end
        S_LERP: begin
          cnt <= cnt + 3'd1;
          if (cnt == STEP_T) state <= S_OUT;
        end
        S_OUT: if (stat.out_free) state <= S_IDLE;
        default: state <= S_CLEAR;
      endcase
    end
  end

  // command decode; in S_SRD the corner word is read at its own address
  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE:  cmd.load = in_valid;
      S_TABW:  cmd.tab_wr = 1'b1;
      S_SIDX:  cmd.samp_idx = 1'b1;
      S_SWR:   cmd.samp_wr = 1'b1;
      S_LIN0: begin
        cmd.tab_sel = SEL_RED;
      end
      S_LIN1: begin
        cmd.tab_sel = SEL_GREEN;
        cmd.lin_cap = 1'b1;
        cmd.lin_sel = SEL_RED;
      end
      S_LIN2: begin
        cmd.tab_sel = SEL_BLUE;
        cmd.lin_cap = 1'b1;
        cmd.lin_sel = SEL_GREEN;
      end
      S_LIN3: begin
        cmd.lin_cap = 1'b1;
        cmd.lin_sel = SEL_BLUE;
      end
      S_PIDX: cmd.pix_idx = 1'b1;
      S_RD: begin
        cmd.cube_rd    = 1'b1;
        cmd.rd_corner  = cnt;
        cmd.word_cap   = (cnt != 3'd0);
        cmd.cap_corner = cnt - 3'd1;
      end
      S_RDL: begin
        cmd.word_cap   = 1'b1;
        cmd.cap_corner = LAST_CORNER;
      end
      S_LERP: begin
        cmd.lerp = 1'b1;
        cmd.step = cnt;
      end
      S_OUT: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

  `RCS_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "word taken while busy")
  `RCS_ASSERT_IMP(a_no_rd_wr, cmd.cube_rd, !(cmd.clr || cmd.samp_wr), "cube read during write")
  `RCS_ASSERT_IMP(a_out_free, cmd.out_load, stat.out_free, "result overwrote pending word")

endmodule

>>> src/rgb_cube_color_separation.sv
// RGB / gray to ink separation through a 3-D lookup cube.
// Input channel (in_valid/in_ready) carries one word per request: a cube
// sample write, a linearization table write, an RGB pixel or a gray pixel.
// Only pixels produce a word on the output channel (out_valid/out_ready).
// Config channel (cfg_valid/cfg_ready, always ready) sets grid_size at
// index 0 and channel_count at index 1; write it only while idle.
// One request is worked at a time. A table write is a single write to the
// table; a sample write is a read-modify-write of the corner word. A pixel
// raises out_valid after 3 table reads, 8 corner reads from the single-port
// cube memory and 7 steps of the shared lerp unit, and holds the input
// until its result is loaded into the output register.
// After reset the cube memory is cleared, one word a cycle, over all
// MAX_GRID^3 words (4096 at the default); in_ready stays low meanwhile.
// The result sits in an output register; a stalled receiver lets the
// next request run, and a second result waits until the first is taken.
module rgb_cube_color_separation #(
  parameter int MAX_GRID = 16,
  parameter int MAX_INKS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] sample_c0,
  input  logic [7:0] sample_c1,
  input  logic [7:0] sample_c2,
  input  logic [7:0] sample_c3,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] sep_c0,
  output logic [7:0] sep_c1,
  output logic [7:0] sep_c2,
  output logic [7:0] sep_c3,
  output logic       last_out
);
  import rcs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  rcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .stat(stat), .cmd(cmd)
  );

  rcs_dp #(.MAX_GRID(MAX_GRID), .MAX_INKS(MAX_INKS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .red(red), .green(green), .blue(blue),
    .sample_c0(sample_c0), .sample_c1(sample_c1),
    .sample_c2(sample_c2), .sample_c3(sample_c3),
    .last_in(last_in), .req_gray(req_type == REQ_GRAY),
    .out_valid(out_valid), .out_ready(out_ready),
    .sep_c0(sep_c0), .sep_c1(sep_c1), .sep_c2(sep_c2), .sep_c3(sep_c3),
    .last_out(last_out)
  );

endmodule
